### hw/rtl/ajq_pkg.sv
// Shared types and constants for the affinity job queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package ajq_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT      = 2'd0,
    REQ_GET      = 2'd1,
    REQ_AFFINITY = 2'd2,
    REQ_RESERVED = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // What the finishing step writes into the response register.
  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_NONE,
    RES_FULL,
    RES_JOB
  } res_kind_e;

  // Where the removal sweep starts.
  typedef enum logic [1:0] {
    POS_HEAD,
    POS_ID,
    POS_ZERO
  } pos_src_e;

  typedef struct packed {
    logic      latch_req;
    logic      put_write;
    logic      scan_start;
    logic      scan_step;
    logic      shift_start;
    pos_src_e  pos_src;
    logic      shift_step;
    logic      cnt_dec;
    logic      load_out;
    res_kind_e res_kind;
  } ajq_cmd_t;

  typedef struct packed {
    req_e req_type;
    logic empty;
    logic full;
    logic last_data;
    logic hit_id;
    logic hit_zero;
    logic overflow;
  } ajq_sts_t;

endpackage

### hw/rtl/ajq_req_if.sv
// Request channel of the affinity job queue: valid/ready and the request fields.
// Depends on ajq_pkg for the field widths.
interface ajq_req_if import ajq_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [TAG_W-1:0]    job_tag;
  logic [HANDLE_W-1:0] job_handle;
  logic [TAG_W-1:0]    requester_id;
  logic                take_overflow;

  modport source (
    output valid, req_type, job_tag, job_handle, requester_id, take_overflow,
    input  ready
  );

  modport sink (
    input  valid, req_type, job_tag, job_handle, requester_id, take_overflow,
    output ready
  );

endinterface

### hw/rtl/ajq_rsp_if.sv
// Response channel of the affinity job queue: valid/ready and the result fields.
// Depends on ajq_pkg for the field widths.
interface ajq_rsp_if import ajq_pkg::*; ();

  logic                valid;
  logic                ready;
  logic                job_valid;
  logic [TAG_W-1:0]    out_tag;
  logic [HANDLE_W-1:0] out_handle;
  logic [STAT_W-1:0]   status;
  logic [OCC_W-1:0]    occupancy;

  modport source (
    output valid, job_valid, out_tag, out_handle, status, occupancy,
    input  ready
  );

  modport sink (
    input  valid, job_valid, out_tag, out_handle, status, occupancy,
    output ready
  );

endinterface

### hw/rtl/ajq_ctrl.sv
// Controller of the affinity job queue: sequences decode, put write, scan, removal sweep
// and response loading. Depends on ajq_pkg for the command and status types.
module ajq_ctrl import ajq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  input  ajq_sts_t sts_i,
  output ajq_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PUT,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_FINISH
  } state_e;

  state_e    state_q, state_d;
  res_kind_e res_kind_q, res_kind_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    res_kind_d  = res_kind_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    cmd_o       = '0;
    cmd_o.res_kind = res_kind_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.req_type)
          REQ_PUT: begin
            if (sts_i.full) begin
              res_kind_d = RES_FULL;
              state_d    = S_FINISH;
            end else begin
              state_d = S_PUT;
            end
          end
          REQ_GET: begin
            if (sts_i.empty) begin
              res_kind_d = RES_NONE;
              state_d    = S_FINISH;
            end else begin
              cmd_o.shift_start = 1'b1;
              cmd_o.pos_src     = POS_HEAD;
              state_d           = S_SHIFT;
            end
          end
          REQ_AFFINITY: begin
            if (sts_i.empty) begin
              res_kind_d = RES_NONE;
              state_d    = S_FINISH;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          REQ_RESERVED: begin
            res_kind_d = RES_PLAIN;
            state_d    = S_FINISH;
          end
          default: begin
            res_kind_d = RES_PLAIN;
            state_d    = S_FINISH;
          end
        endcase
      end
      S_PUT: begin
        cmd_o.put_write = 1'b1;
        res_kind_d      = RES_PLAIN;
        state_d         = S_FINISH;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.last_data) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        // A requester match wins; tag 0 work is the fallback when allowed.
        priority if (sts_i.hit_id) begin
          cmd_o.shift_start = 1'b1;
          cmd_o.pos_src     = POS_ID;
          state_d           = S_SHIFT;
        end else if (sts_i.overflow && sts_i.hit_zero) begin
          cmd_o.shift_start = 1'b1;
          cmd_o.pos_src     = POS_ZERO;
          state_d           = S_SHIFT;
        end else begin
          res_kind_d = RES_NONE;
          state_d    = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.last_data) begin
          cmd_o.cnt_dec = 1'b1;
          res_kind_d    = RES_JOB;
          state_d       = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_kind_q  <= RES_PLAIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_kind_q  <= res_kind_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hw/rtl/ajq_dp.sv
// Datapath of the affinity job queue: entry memories, occupancy counter, scan
// compare, removal sweep and response register. Depends on ajq_pkg.
module ajq_dp import ajq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ajq_cmd_t            cmd_i,
  output ajq_sts_t            sts_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [TAG_W-1:0]    job_tag_i,
  input  logic [HANDLE_W-1:0] job_handle_i,
  input  logic [TAG_W-1:0]    requester_id_i,
  input  logic                take_overflow_i,
  output logic                job_valid_o,
  output logic [TAG_W-1:0]    out_tag_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [STAT_W-1:0]   status_o,
  output logic [OCC_W-1:0]    occupancy_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [TAG_BITS-1:0] tag_mem [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] hdl_mem [QUEUE_DEPTH];

  // Latched request.
  req_e                req_type_q;
  logic [TAG_W-1:0]    req_tag_q;
  logic [HANDLE_W-1:0] req_hdl_q;
  logic [TAG_W-1:0]    req_rid_q;
  logic                req_ovf_q;

  logic [CW-1:0]       cnt_q;
  logic [CW-1:0]       rp_q;
  logic                rd_vld_q;
  logic [AW-1:0]       rd_idx_q;
  logic [TAG_BITS-1:0] tag_rd_q;
  logic [HANDLE_W-1:0] hdl_rd_q;

  logic                hit_id_q, hit_zero_q;
  logic [AW-1:0]       pos_id_q, pos_zero_q, pos_q;
  logic [TAG_BITS-1:0] cap_tag_q;
  logic [HANDLE_W-1:0] cap_hdl_q;

  logic                out_job_q;
  logic [TAG_W-1:0]    out_tag_q;
  logic [HANDLE_W-1:0] out_hdl_q;
  status_e             out_status_q;
  logic [OCC_W-1:0]    out_occ_q;

  logic                rd_en;
  logic                last_data;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [TAG_BITS-1:0] mem_wtag;
  logic [HANDLE_W-1:0] mem_whdl;
  logic [TAG_BITS-1:0] rid_tag;
  logic                shift_data;
  logic [AW-1:0]       start_pos;

  assign rid_tag   = TAG_BITS'(req_rid_q);
  assign rd_en     = (cmd_i.scan_step || cmd_i.shift_step) && (rp_q < cnt_q);
  assign last_data = rd_vld_q && (CW'(rd_idx_q) == cnt_q - CW'(1));
  // Every entry read after the removed one moves down by one place.
  assign shift_data = cmd_i.shift_step && rd_vld_q;

  assign mem_we   = cmd_i.put_write || (shift_data && (rd_idx_q != pos_q));
  assign mem_wa   = cmd_i.put_write ? cnt_q[AW-1:0] : rd_idx_q - AW'(1);
  assign mem_wtag = cmd_i.put_write ? TAG_BITS'(req_tag_q) : tag_rd_q;
  assign mem_whdl = cmd_i.put_write ? req_hdl_q : hdl_rd_q;

  always_comb begin
    unique case (cmd_i.pos_src)
      POS_ID:   start_pos = pos_id_q;
      POS_ZERO: start_pos = pos_zero_q;
      default:  start_pos = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_wa] <= mem_wtag;
      hdl_mem[mem_wa] <= mem_whdl;
    end
    if (rd_en) begin
      tag_rd_q <= tag_mem[rp_q[AW-1:0]];
      hdl_rd_q <= hdl_mem[rp_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      hit_id_q   <= 1'b0;
      hit_zero_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.put_write) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.scan_start) begin
        hit_id_q   <= 1'b0;
        hit_zero_q <= 1'b0;
      end else if (cmd_i.scan_step && rd_vld_q) begin
        if (!hit_id_q && (tag_rd_q == rid_tag)) begin
          hit_id_q <= 1'b1;
        end
        if (!hit_zero_q && (tag_rd_q == '0)) begin
          hit_zero_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_type_q <= req_e'(req_type_i);
      req_tag_q  <= job_tag_i;
      req_hdl_q  <= job_handle_i;
      req_rid_q  <= requester_id_i;
      req_ovf_q  <= take_overflow_i;
    end

    if (rd_en) begin
      rd_idx_q <= rp_q[AW-1:0];
    end

    if (cmd_i.scan_start) begin
      rp_q <= '0;
    end else if (cmd_i.shift_start) begin
      rp_q  <= CW'(start_pos);
      pos_q <= start_pos;
    end else if (rd_en) begin
      rp_q <= rp_q + CW'(1);
    end

    if (cmd_i.scan_step && rd_vld_q) begin
      if (!hit_id_q && (tag_rd_q == rid_tag)) begin
        pos_id_q <= rd_idx_q;
      end
      if (!hit_zero_q && (tag_rd_q == '0)) begin
        pos_zero_q <= rd_idx_q;
      end
    end

    if (shift_data && (rd_idx_q == pos_q)) begin
      cap_tag_q <= tag_rd_q;
      cap_hdl_q <= hdl_rd_q;
    end

    if (cmd_i.load_out) begin
      out_occ_q <= OCC_W'(cnt_q);
      unique case (cmd_i.res_kind)
        RES_JOB: begin
          out_job_q    <= 1'b1;
          out_tag_q    <= TAG_W'(cap_tag_q);
          out_hdl_q    <= cap_hdl_q;
          out_status_q <= ST_OK;
        end
        RES_NONE: begin
          out_job_q    <= 1'b0;
          out_tag_q    <= '0;
          out_hdl_q    <= '0;
          out_status_q <= ST_NONE;
        end
        RES_FULL: begin
          out_job_q    <= 1'b0;
          out_tag_q    <= '0;
          out_hdl_q    <= '0;
          out_status_q <= ST_FULL;
        end
        default: begin
          out_job_q    <= 1'b0;
          out_tag_q    <= '0;
          out_hdl_q    <= '0;
          out_status_q <= ST_OK;
        end
      endcase
    end
  end

  assign sts_o.req_type  = req_type_q;
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.full      = (cnt_q == CW'(QUEUE_DEPTH));
  assign sts_o.last_data = last_data;
  assign sts_o.hit_id    = hit_id_q;
  assign sts_o.hit_zero  = hit_zero_q;
  assign sts_o.overflow  = req_ovf_q;

  assign job_valid_o  = out_job_q;
  assign out_tag_o    = out_tag_q;
  assign out_handle_o = out_hdl_q;
  assign status_o     = out_status_q;
  assign occupancy_o  = out_occ_q;

endmodule

### hw/rtl/affinity_job_queue.sv
// Affinity job queue, top level. A put, a refused put, a reserved request and a get on an
// empty queue take a time that does not depend on the fill; a plain get sweeps the entries
// from the head, and an affinity get scans them all and, on a match, sweeps again from it.
// One memory read port is swept an entry a cycle by the tag scan and by the removal.
// A new request is accepted once the previous response is registered; a held one stalls.
// Reset empties the queue at once; the entry memories need no clearing pass.
module affinity_job_queue import ajq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ajq_req_if.sink   req_i,
  ajq_rsp_if.source rsp_o
);

  ajq_cmd_t cmd;
  ajq_sts_t sts;
  logic     req_ready;
  logic     rsp_valid;

  ajq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ajq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_i.req_type),
    .job_tag_i       (req_i.job_tag),
    .job_handle_i    (req_i.job_handle),
    .requester_id_i  (req_i.requester_id),
    .take_overflow_i (req_i.take_overflow),
    .job_valid_o     (rsp_o.job_valid),
    .out_tag_o       (rsp_o.out_tag),
    .out_handle_o    (rsp_o.out_handle),
    .status_o        (rsp_o.status),
    .occupancy_o     (rsp_o.occupancy)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;

`ifndef SYNTH
  // A request is worked on alone: no second request is taken the cycle after one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while the previous one is still in progress");

  // The tail is written only when there is room.
  a_put_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.put_write |-> !sts.full)
    else $error("put written into a full queue");

  // A pending response is never overwritten before it is taken.
  a_rsp_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!rsp_o.valid || rsp_o.ready))
    else $error("response register reloaded while a response is pending");

  // Removal sweeps and scans only run on a non-empty queue.
  a_sweep_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_start || cmd.shift_start |-> !sts.empty)
    else $error("sweep started on an empty queue");
`endif

endmodule
